// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLKD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ial_pkg.sv =====
// Package for the indexed array list: request codes, field widths and cell control.
package ial_pkg;

    localparam int DEPTH_DEF = 64;

    // field widths
    localparam int REQ_W     = 3;
    localparam int IDX_W     = 7;
    localparam int VAL_W     = 32;
    localparam int FOUND_W   = 6;
    localparam int CNT_OUT_W = 7;

    // stream widths
    localparam int S_TDATA_W = 40;  // index, value
    localparam int S_TUSER_W = 3;   // req_type
    localparam int M_TDATA_W = 48;  // ok, found_index, read_value, count, empty_res

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL_AT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_VAL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

    // shift operation applied across the cell row
    typedef logic [1:0] shift_t;
    localparam shift_t SH_NONE = 2'd0;
    localparam shift_t SH_UP   = 2'd1;  // open a slot at pos, take value there
    localparam shift_t SH_DOWN = 2'd2;  // close the slot at pos

    typedef struct packed {
        logic              cmp_en;   // register match and read word this cycle
        shift_t            shift_op;
        logic [VAL_W-1:0]  value;    // key for compare, word for insert
    } ial_ctrl_t;

endpackage

// ===== rtl/core/ial_cell.sv =====
// One storage cell of the list: holds a word, compares it and shifts with its neighbours.
module ial_cell #(
    parameter int PW       = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                        aclk,
    input  ial_pkg::ial_ctrl_t          ctrl,
    input  logic [PW-1:0]               start,
    input  logic [PW-1:0]               count,
    input  logic [PW-1:0]               pos,
    input  logic [ial_pkg::VAL_W-1:0]   left_word,
    input  logic [ial_pkg::VAL_W-1:0]   right_word,
    output logic [ial_pkg::VAL_W-1:0]   word,
    output logic                        match,
    output logic [ial_pkg::VAL_W-1:0]   rd_word
);

    localparam logic [PW-1:0] MY_POS = PW'(CELL_IDX);

    logic [ial_pkg::VAL_W-1:0] word_reg, word_next;
    logic                      match_reg, match_next;
    logic [ial_pkg::VAL_W-1:0] rdw_reg, rdw_next;

    always_comb begin
        word_next  = word_reg;
        match_next = match_reg;
        rdw_next   = rdw_reg;
        if (ctrl.cmp_en) begin
            match_next = (word_reg == ctrl.value) && (MY_POS >= start) && (MY_POS < count);
            rdw_next   = (MY_POS == start) ? word_reg : '0;
        end
        case (ctrl.shift_op)
            ial_pkg::SH_UP: begin
                if (MY_POS > pos) begin
                    word_next = left_word;
                end else if (MY_POS == pos) begin
                    word_next = ctrl.value;
                end
            end
            ial_pkg::SH_DOWN: begin
                if (MY_POS >= pos) begin
                    word_next = right_word;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
        rdw_reg   <= rdw_next;
    end

    assign word    = word_reg;
    assign match   = match_reg;
    assign rd_word = rdw_reg;

endmodule

// ===== rtl/core/indexed_array_list_top.sv =====
// Top level of the indexed array list: request sequencer, cell row and result register.
// Usage
//   Requests enter on the s_ stream: s_tuser carries req_type, s_tdata carries
//   index and value. Each request gives exactly one result item on the m_
//   stream carrying ok, found_index, read_value, the new count and empty_res.
//   An item is taken at an edge where tvalid and tready are both high.
// Timing
//   An accepted item passes through the compare step (every cell checks its
//   word against the key and start position and latches the word at the
//   index), then through the resolve step (first-match select across the
//   row, read-word merge, and the shift of the whole row). The block takes
//   no new item until the resolve step has loaded the result register, since
//   s_tready is high only in the idle step ahead of the compare and resolve steps.
// Stall
//   s_tready comes back as soon as the resolve step has loaded the result
//   register, even while that item still waits. If the register is still held
//   by a stalled receiver, the resolve step waits and the row is left untouched.
// Reset
//   aresetn (synchronous, active low) empties the list and drops m_tvalid.
//   Stored words are not cleared; only positions below count are ever read.
module indexed_array_list_top #(
    parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ial_pkg::S_TDATA_W-1:0]   s_tdata,   // index[6:0], value[38:7], zero fill
    input  logic [ial_pkg::S_TUSER_W-1:0]   s_tuser,   // req_type[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ial_pkg::M_TDATA_W-1:0]   m_tdata    // ok[0], found_index[6:1],
                                                       // read_value[38:7], count[45:39],
                                                       // empty_res[46], zero fill
);

    localparam int IDX_W = ial_pkg::IDX_W;
    localparam int VAL_W = ial_pkg::VAL_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // position width: holds both the index field and the count
    localparam int PW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [PW-1:0] DEPTH_PW = PW'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [ial_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [PW-1:0]               idx_reg, idx_next;
    logic [VAL_W-1:0]            val_reg, val_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic [ial_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic s_accept;
    logic out_free;
    logic load_res;

    // zero-extension helpers
    logic [PW+IDX_W-1:0]              idx_ext;
    logic [PW+CNT_W-1:0]              cnt_ext;
    logic [PW-1:0]                    cnt_pw;

    // cell row
    ial_pkg::ial_ctrl_t          ctrl;
    logic [VAL_W-1:0]            cell_word [DEPTH];
    logic [VAL_W-1:0]            cell_rdw  [DEPTH];
    logic [DEPTH-1:0]            cell_match;
    logic [PW-1:0]               shift_pos;

    // resolve step
    logic                        hit;
    logic [PW-1:0]               hit_pos;
    logic [VAL_W-1:0]            rd_merge;
    logic                        ok_c;
    logic [PW-1:0]               found_c;
    logic [VAL_W-1:0]            rd_c;
    logic [CNT_W-1:0]            cnt_res;
    ial_pkg::shift_t             shift_c;
    logic [PW+ial_pkg::FOUND_W-1:0]   found_ext;
    logic [CNT_W+ial_pkg::CNT_OUT_W-1:0] cnt_out_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_res = (state_reg == ST_RES) && out_free;

    assign idx_ext = {{PW{1'b0}}, s_tdata[IDX_W-1:0]};
    assign cnt_ext = {{PW{1'b0}}, cnt_reg};
    assign cnt_pw  = cnt_ext[PW-1:0];

    // first match across the row and merged read word
    always_comb begin
        hit      = 1'b0;
        hit_pos  = '0;
        rd_merge = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                hit     = 1'b1;
                hit_pos = PW'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            rd_merge = rd_merge | cell_rdw[i];
        end
    end

    // request outcome
    always_comb begin
        ok_c      = 1'b0;
        found_c   = '0;
        rd_c      = '0;
        cnt_res   = cnt_reg;
        shift_c   = ial_pkg::SH_NONE;
        shift_pos = idx_reg;
        case (req_reg)
            ial_pkg::REQ_INSERT: begin
                if ((cnt_pw < DEPTH_PW) && (idx_reg <= cnt_pw)) begin
                    ok_c    = 1'b1;
                    shift_c = ial_pkg::SH_UP;
                    cnt_res = cnt_reg + 1'b1;
                end
            end
            ial_pkg::REQ_DEL_AT: begin
                if (idx_reg < cnt_pw) begin
                    ok_c    = 1'b1;
                    shift_c = ial_pkg::SH_DOWN;
                    cnt_res = cnt_reg - 1'b1;
                end
            end
            ial_pkg::REQ_DEL_VAL: begin
                shift_pos = hit_pos;
                if (hit) begin
                    ok_c    = 1'b1;
                    found_c = hit_pos;
                    shift_c = ial_pkg::SH_DOWN;
                    cnt_res = cnt_reg - 1'b1;
                end
            end
            ial_pkg::REQ_SEARCH: begin
                if (hit) begin
                    ok_c    = 1'b1;
                    found_c = hit_pos;
                end
            end
            ial_pkg::REQ_GET: begin
                if (idx_reg < cnt_pw) begin
                    ok_c = 1'b1;
                    rd_c = rd_merge;
                end
            end
            ial_pkg::REQ_CLEAR: begin
                ok_c    = 1'b1;
                cnt_res = '0;
            end
            default: begin
            end
        endcase
    end

    assign found_ext   = {{ial_pkg::FOUND_W{1'b0}}, found_c};
    assign cnt_out_ext = {{ial_pkg::CNT_OUT_W{1'b0}}, cnt_res};

    assign ctrl.cmp_en   = (state_reg == ST_CMP);
    assign ctrl.shift_op = load_res ? shift_c : ial_pkg::SH_NONE;
    assign ctrl.value    = val_reg;

    // sequencer and result register
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next   = s_tuser;
                    idx_next   = idx_ext[PW-1:0];
                    val_next   = s_tdata[IDX_W+VAL_W-1:IDX_W];
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_RES;
            end
            ST_RES: begin
                if (load_res) begin
                    cnt_next     = cnt_res;
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, (cnt_res == '0),
                                    cnt_out_ext[ial_pkg::CNT_OUT_W-1:0],
                                    rd_c, found_ext[ial_pkg::FOUND_W-1:0], ok_c};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        m_data_reg <= m_data_next;
    end

    // row of cells, each linked to its neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_inner_l
            assign left_w = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner_r
            assign right_w = cell_word[g+1];
        end
        ial_cell #(
            .PW       (PW),
            .CELL_IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .start      (idx_reg),
            .count      (cnt_pw),
            .pos        (shift_pos),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[g]),
            .match      (cell_match[g]),
            .rd_word    (cell_rdw[g])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/ial_checker.sv =====
// Port-level checks for the indexed array list, bound to the top level.
`include "assert_macros.svh"

module ial_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ial_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [ial_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ial_pkg::M_TDATA_W-1:0]   m_tdata
);

    // result held while stalled
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // no result straight out of reset
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid)

    // one item at a time: busy the cycle after an accept
    `ASSERT_CLKD(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // empty flag agrees with the count
    `ASSERT_CLKD(a_empty_flag, aclk, aresetn, m_tvalid |-> (m_tdata[46] == (m_tdata[45:39] == 7'd0)))

    // a failed request carries no position and no word
    `ASSERT_CLKD(a_fail_zero, aclk, aresetn, m_tvalid && !m_tdata[0] |-> (m_tdata[38:1] == 38'd0))

endmodule

bind indexed_array_list_top ial_checker u_ial_checker (.*);
